[hdl/htce_pkg.sv]
// Package for the HTML table cell extractor: parser state types, character
// constants and the whitespace test. No dependencies.
package htce_pkg;

    typedef enum logic [1:0]
    {
        MODE_TEXT   = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_FROZEN = 2'd2,
        MODE_ATTR   = 2'd3
    } mode_t;

    typedef enum logic [1:0]
    {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CASE_FOLD = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] NAME_LEN_MAX  = 3'd4;
    localparam logic [2:0] NAME_LEN_HEAD = 3'd3;

    typedef struct packed
    {
        mode_t            mode;
        quote_t           quote;
        logic             inside_cell;
        logic             last_was_space;
        logic [2:0][7:0]  tag_head;
        logic [2:0]       name_len;
    } state_t;

    typedef struct packed
    {
        logic       emit;
        logic [7:0] data;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

[hdl/html_table_cell_extractor_core.sv]
// Top level of the HTML table cell extractor: parser state register, step
// logic and output buffer. Depends on htce_pkg, htce_step and htce_out_buf.
//
// Usage:
//   Input channel (in_valid, in_stall, in_byte, end_of_file): one text byte
//   per transaction. A transaction with end_of_file high returns the parser
//   to its reset state and produces nothing; its byte is ignored.
//   Output channel (out_valid, out_stall, out_byte): cell text with runs of
//   whitespace folded to one space, ';' after each closing TD tag and a
//   newline after each closing TR tag. A byte outside a cell produces nothing.
//   A result is registered: it goes into the result register, or into the
//   skid register while a result waits. Throughput: one byte per cycle while
//   in_stall is low, set by the state register that each accept updates.
//   Stall: the result register is backed by a skid register, so one more
//   byte is taken while a result waits; in_stall rises only once both hold
//   data, and drops as soon as the receiver takes one.
//   Reset: rst_n is asynchronous and active low; it clears the parser state
//   and empties the output buffer. in_stall is low straight after reset.
module html_table_cell_extractor_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_file,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte
);

    htce_pkg::state_t  state_reg;
    htce_pkg::state_t  state_next;
    htce_pkg::state_t  step_state;
    htce_pkg::result_t step_res;
    logic              buf_full;
    logic              accept;

    // take a transaction whenever the skid register is free
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    htce_step u_step
    (
        .cur         (state_reg),
        .in_byte     (in_byte),
        .end_of_file (end_of_file),
        .nxt         (step_state),
        .res         (step_res)
    );

    // hold the state unless a transaction is taken
    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= htce_pkg::MODE_TEXT;
            state_reg.quote          <= htce_pkg::Q_NONE;
            state_reg.inside_cell    <= 1'b0;
            state_reg.last_was_space <= 1'b0;
            state_reg.tag_head       <= '0;
            state_reg.name_len       <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // results go straight into the output buffer
    htce_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && step_res.emit),
        .push_data (step_res.data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

endmodule

[hdl/htce_step.sv]
// Next-state and result logic for one byte of the cell extractor.
// Depends on htce_pkg.
module htce_step
(
    input  htce_pkg::state_t  cur,
    input  logic [7:0]        in_byte,
    input  logic              end_of_file,
    output htce_pkg::state_t  nxt,
    output htce_pkg::result_t res
);

    logic       is_td;
    logic       is_close_td;
    logic       is_close_tr;
    logic [7:0] folded;

    assign is_td = (cur.name_len == 3'd2) && (cur.tag_head[0] == htce_pkg::CH_T)
                   && (cur.tag_head[1] == htce_pkg::CH_D);
    assign is_close_td = (cur.name_len == 3'd3) && (cur.tag_head[0] == htce_pkg::CH_SLASH)
                         && (cur.tag_head[1] == htce_pkg::CH_T)
                         && (cur.tag_head[2] == htce_pkg::CH_D);
    assign is_close_tr = (cur.name_len == 3'd3) && (cur.tag_head[0] == htce_pkg::CH_SLASH)
                         && (cur.tag_head[1] == htce_pkg::CH_T)
                         && (cur.tag_head[2] == htce_pkg::CH_R);
    assign folded = ((in_byte >= htce_pkg::CH_LC_A) && (in_byte <= htce_pkg::CH_LC_Z))
                    ? (in_byte - htce_pkg::CASE_FOLD) : in_byte;

    always_comb
    begin
        logic finish;
        nxt      = cur;
        res.emit = 1'b0;
        res.data = '0;
        finish   = 1'b0;

        if (end_of_file)
        begin
            nxt.mode           = htce_pkg::MODE_TEXT;
            nxt.quote          = htce_pkg::Q_NONE;
            nxt.inside_cell    = 1'b0;
            nxt.last_was_space = 1'b0;
            nxt.name_len       = '0;
        end
        else
        begin
            case (cur.mode)
                htce_pkg::MODE_TEXT:
                begin
                    if (in_byte == htce_pkg::CH_LT)
                    begin
                        nxt.mode     = htce_pkg::MODE_NAME;
                        nxt.quote    = htce_pkg::Q_NONE;
                        nxt.name_len = '0;
                    end
                    else if (cur.inside_cell)
                    begin
                        if (htce_pkg::is_ws(in_byte))
                        begin
                            if (!cur.last_was_space)
                            begin
                                nxt.last_was_space = 1'b1;
                                res.emit           = 1'b1;
                                res.data           = htce_pkg::CH_SPACE;
                            end
                        end
                        else
                        begin
                            nxt.last_was_space = 1'b0;
                            res.emit           = 1'b1;
                            res.data           = in_byte;
                        end
                    end
                end
                htce_pkg::MODE_NAME,
                htce_pkg::MODE_FROZEN:
                begin
                    if (in_byte == htce_pkg::CH_GT)
                    begin
                        finish = 1'b1;
                    end
                    else if (htce_pkg::is_ws(in_byte))
                    begin
                        nxt.mode  = htce_pkg::MODE_ATTR;
                        nxt.quote = htce_pkg::Q_NONE;
                    end
                    else if (cur.mode == htce_pkg::MODE_NAME)
                    begin
                        if (in_byte == htce_pkg::CH_NUL)
                        begin
                            nxt.mode = htce_pkg::MODE_FROZEN;
                        end
                        else
                        begin
                            if (cur.name_len < htce_pkg::NAME_LEN_HEAD)
                            begin
                                nxt.tag_head[cur.name_len[1:0]] = folded;
                            end
                            if (cur.name_len < htce_pkg::NAME_LEN_MAX)
                            begin
                                nxt.name_len = cur.name_len + 3'd1;
                            end
                        end
                    end
                end
                htce_pkg::MODE_ATTR:
                begin
                    if (in_byte == htce_pkg::CH_SQUOTE)
                    begin
                        if (cur.quote == htce_pkg::Q_SINGLE)
                            nxt.quote = htce_pkg::Q_NONE;
                        else if (cur.quote == htce_pkg::Q_NONE)
                            nxt.quote = htce_pkg::Q_SINGLE;
                    end
                    else if (in_byte == htce_pkg::CH_DQUOTE)
                    begin
                        if (cur.quote == htce_pkg::Q_DOUBLE)
                            nxt.quote = htce_pkg::Q_NONE;
                        else if (cur.quote == htce_pkg::Q_NONE)
                            nxt.quote = htce_pkg::Q_DOUBLE;
                    end
                    else if ((in_byte == htce_pkg::CH_GT) && (cur.quote == htce_pkg::Q_NONE))
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    nxt.mode = htce_pkg::MODE_TEXT;
                end
            endcase

            // act on a completed tag
            if (finish)
            begin
                nxt.mode  = htce_pkg::MODE_TEXT;
                nxt.quote = htce_pkg::Q_NONE;
                if (is_td)
                begin
                    nxt.inside_cell = 1'b1;
                end
                else if (is_close_td)
                begin
                    nxt.inside_cell    = 1'b0;
                    nxt.last_was_space = 1'b0;
                    res.emit           = 1'b1;
                    res.data           = htce_pkg::CH_SEMI;
                end
                else if (is_close_tr)
                begin
                    res.emit = 1'b1;
                    res.data = htce_pkg::CH_NL;
                end
            end
        end
    end

endmodule

[hdl/htce_out_buf.sv]
// Two-entry output buffer (result register plus skid register) for the
// cell extractor. No dependencies.
module htce_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte
);

    logic       main_valid_reg;
    logic       main_valid_next;
    logic [7:0] main_data_reg;
    logic [7:0] main_data_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic [7:0] skid_data_reg;
    logic [7:0] skid_data_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || !out_stall)
        begin
            // main slot frees up: refill from skid first, else from push
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_byte  = main_data_reg;

endmodule

[bench/htce_checker.sv]
// Checker for the HTML table cell extractor: follows both channels, predicts
// each output byte and compares it. Depends on htce_pkg.
`timescale 1ns / 1ps

module htce_checker
    import htce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_file,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    output int         mismatches,
    output int         bytes_due
);

    localparam logic [2:0] TD_NAME_LEN = 3'd2;
    localparam int         REPORT_MAX  = 10;

    // Own copy of the parser state
    mode_t      scan_mode;
    quote_t     open_quote;
    logic       in_cell;
    logic       space_sent;
    logic [7:0] name_head [3];
    logic [2:0] name_len;

    logic [7:0] cell_text_due [$];

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void clear_parser();
        scan_mode  = MODE_TEXT;
        open_quote = Q_NONE;
        in_cell    = 1'b0;
        space_sent = 1'b0;
        name_len   = '0;
        for (int i = 0; i < 3; i++)
            name_head[i] = '0;
    endfunction

    // Act on a finished tag; returns 1 when it emits a byte
    function automatic logic close_tag(output logic [7:0] emitted);
        emitted    = '0;
        scan_mode  = MODE_TEXT;
        open_quote = Q_NONE;
        if (name_len == TD_NAME_LEN && name_head[0] == CH_T && name_head[1] == CH_D)
        begin
            in_cell = 1'b1;
            return 1'b0;
        end
        if (name_len == NAME_LEN_HEAD && name_head[0] == CH_SLASH && name_head[1] == CH_T)
        begin
            if (name_head[2] == CH_D)
            begin
                in_cell    = 1'b0;
                space_sent = 1'b0;
                emitted    = CH_SEMI;
                return 1'b1;
            end
            if (name_head[2] == CH_R)
            begin
                emitted = CH_NL;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the parser by one transaction; returns 1 when a byte is emitted
    function automatic logic extract_step(input logic [7:0] b, input logic eof,
                                          output logic [7:0] emitted);
        logic [7:0] c;
        quote_t     kind;
        c       = b;
        emitted = '0;
        if (eof)
        begin
            clear_parser();
            return 1'b0;
        end
        case (scan_mode)
            MODE_TEXT:
            begin
                if (c == CH_LT)
                begin
                    scan_mode  = MODE_NAME;
                    open_quote = Q_NONE;
                    name_len   = '0;
                    return 1'b0;
                end
                if (!in_cell)
                    return 1'b0;
                if (is_blank(c))
                begin
                    if (space_sent)
                        return 1'b0;
                    space_sent = 1'b1;
                    emitted    = CH_SPACE;
                    return 1'b1;
                end
                space_sent = 1'b0;
                emitted    = c;
                return 1'b1;
            end
            MODE_NAME, MODE_FROZEN:
            begin
                if (c == CH_GT)
                    return close_tag(emitted);
                if (is_blank(c))
                begin
                    scan_mode  = MODE_ATTR;
                    open_quote = Q_NONE;
                    return 1'b0;
                end
                if (scan_mode == MODE_FROZEN)
                    return 1'b0;
                if (c == CH_NUL)
                begin
                    scan_mode = MODE_FROZEN;
                    return 1'b0;
                end
                if (c >= CH_LC_A && c <= CH_LC_Z)
                    c = c - CASE_FOLD;
                if (name_len < NAME_LEN_HEAD)
                    name_head[name_len[1:0]] = c;
                if (name_len < NAME_LEN_MAX)
                    name_len = name_len + 3'd1;
                return 1'b0;
            end
            default:
            begin
                if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    kind = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                    if (open_quote == kind)
                        open_quote = Q_NONE;
                    else if (open_quote == Q_NONE)
                        open_quote = kind;
                    return 1'b0;
                end
                if (c == CH_GT && open_quote == Q_NONE)
                    return close_tag(emitted);
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: expected 8'h%02h, got 8'h%02h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        logic [7:0] next_byte;
        if (!rst_n)
        begin
            clear_parser();
            cell_text_due.delete();
            mismatches = 0;
            bytes_due  = 0;
        end
        else
        begin
            // Retire the output transaction first: it can never belong to
            // an input taken at this same edge
            if (out_valid && !out_stall)
            begin
                if (cell_text_due.size() == 0)
                    report_mismatch("unexpected output byte", 8'h00, out_byte);
                else
                begin
                    want = cell_text_due.pop_front();
                    if (want != out_byte)
                        report_mismatch("output byte mismatch", want, out_byte);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (extract_step(in_byte, end_of_file, next_byte))
                    cell_text_due.push_back(next_byte);
            end
            bytes_due = cell_text_due.size();
        end
    end

endmodule

[bench/tb.sv]
// Testbench top for the HTML table cell extractor: clock, reset, byte stream
// stimulus and verdict. Depends on htce_pkg, htce_checker and the core.
`timescale 1ns / 1ps

module tb;
    import htce_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int IDLE_PCT    = 28;
    // Transactions inside this window run with no idling on either side
    localparam int CALM_FIRST  = 500;
    localparam int CALM_LAST   = 700;
    localparam int DRAIN_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_file;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;

    int mismatches;
    int bytes_due;
    int sent;

    html_table_cell_extractor_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_file (end_of_file),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte)
    );

    htce_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_file (end_of_file),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .mismatches  (mismatches),
        .bytes_due   (bytes_due)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic calm();
        return (sent >= CALM_FIRST) && (sent < CALM_LAST);
    endfunction

    function automatic logic take_rest();
        return !calm() && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Receiver: stall at random, except in the calm window
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= take_rest();
    end

    // Present one byte and hold it until the transaction is taken; returns
    // at the falling edge after acceptance
    task automatic push(input logic [7:0] b, input logic eof);
        while (take_rest())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(0, 1))
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'($urandom_range("a", "z"));
        if ($urandom_range(0, 1))
            c = c - CASE_FOLD;
        return c;
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] upper);
        if ($urandom_range(0, 1))
            return upper + CASE_FOLD;
        return upper;
    endfunction

    // Name byte that neither ends the name nor freezes it
    function automatic logic [7:0] pick_name_byte();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: c = mixed_case(CH_T);
            1: c = mixed_case(CH_D);
            2: c = mixed_case(CH_R);
            3: c = CH_SLASH;
            4: c = ($urandom_range(0, 1)) ? CH_SQUOTE : CH_DQUOTE;
            5: c = pick_letter();
            default:
            begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_GT || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    c = CH_LC_A;
            end
        endcase
        return c;
    endfunction

    task automatic push_name();
        int n;
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                push(mixed_case(CH_T), 1'b0);
                push(mixed_case(CH_D), 1'b0);
            end
            3, 4:
            begin
                push(CH_SLASH, 1'b0);
                push(mixed_case(CH_T), 1'b0);
                push(mixed_case(CH_D), 1'b0);
            end
            5, 6:
            begin
                push(CH_SLASH, 1'b0);
                push(mixed_case(CH_T), 1'b0);
                push(mixed_case(CH_R), 1'b0);
            end
            7, 8:
            begin
                n = $urandom_range(0, 3);
                repeat (n)
                    push(pick_name_byte(), 1'b0);
            end
            9:
            begin
                // Long name: length saturates and nothing matches
                n = $urandom_range(4, 7);
                repeat (n)
                    push(pick_name_byte(), 1'b0);
            end
            default:
            begin
                // NUL cuts the name; the bytes after it are dropped
                n = $urandom_range(0, 3);
                repeat (n)
                    push(pick_name_byte(), 1'b0);
                push(CH_NUL, 1'b0);
                n = $urandom_range(0, 3);
                repeat (n)
                    push(($urandom_range(0, 2) == 0) ? CH_NUL : pick_name_byte(), 1'b0);
            end
        endcase
    endtask

    // Attributes with balanced quotes, so a '>' inside a string is skipped
    task automatic push_attributes();
        quote_t     q;
        logic [7:0] c;
        int         n;
        q = Q_NONE;
        push(pick_blank(), 1'b0);
        n = $urandom_range(0, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0: c = CH_SQUOTE;
                1: c = CH_DQUOTE;
                2: c = (q == Q_NONE) ? CH_SPACE : CH_GT;
                3: c = pick_blank();
                4: c = 8'h3D;
                default: c = pick_letter();
            endcase
            if (c == CH_SQUOTE || c == CH_DQUOTE)
            begin
                if (q == Q_NONE)
                    q = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                else if ((q == Q_SINGLE) == (c == CH_SQUOTE))
                    q = Q_NONE;
            end
            push(c, 1'b0);
        end
        if (q == Q_SINGLE)
            push(CH_SQUOTE, 1'b0);
        else if (q == Q_DOUBLE)
            push(CH_DQUOTE, 1'b0);
    endtask

    task automatic push_tag();
        push(CH_LT, 1'b0);
        push_name();
        if ($urandom_range(0, 1))
            push_attributes();
        // Occasionally cut the tag off with an end of file, or leave it
        // open so that the next text is swallowed as attributes
        case ($urandom_range(0, 19))
            0:       push(8'($urandom), 1'b1);
            1:       ;
            default: push(CH_GT, 1'b0);
        endcase
    endtask

    task automatic push_cell_text();
        logic [7:0] c;
        int         n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: c = pick_letter();
                8, 9, 10, 11, 12:       c = pick_blank();
                default:
                begin
                    c = 8'($urandom);
                    if (c == CH_LT)
                        c = 8'hFF;
                end
            endcase
            push(c, 1'b0);
        end
    endtask

    initial
    begin
        int drain;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = '0;
        end_of_file = 1'b0;
        out_stall   = 1'b0;
        sent        = 0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: lower-case TD, byte extremes, whitespace run,
        // NUL inside a tag name, a quoted '>' in attributes, end of file
        push_text("<td>");
        push(8'hFF, 1'b0);
        push(CH_NUL, 1'b0);
        push(CH_SPACE, 1'b0);
        push(CH_TAB, 1'b0);
        push("a", 1'b0);
        push_text("<t");
        push(CH_NUL, 1'b0);
        push_text("x>");
        push_text("</TD '>'>");
        push(8'hFF, 1'b1);

        // Random part: mostly tags and cell text, some noise and resets
        while (sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 99))
                0, 1, 2:              push(8'($urandom), 1'b1);
                3, 4, 5, 6, 7, 8, 9:  push(8'($urandom), 1'b0);
                default:
                begin
                    if ($urandom_range(0, 1))
                        push_tag();
                    else
                        push_cell_text();
                end
            endcase
        end
        in_valid <= 1'b0;

        // Drain, then wait on for any stray output
        drain = 0;
        while (bytes_due != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (5)
            @(negedge clk);

        if (mismatches == 0 && bytes_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
